FILE: hw/rtl/level_window_shortest_path_core_macros.svh
// Assertion macros used by the core RTL file.
`ifndef LEVEL_WINDOW_SHORTEST_PATH_CORE_MACROS_SVH
`define LEVEL_WINDOW_SHORTEST_PATH_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define LWSP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define LWSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");
`endif

FILE: hw/rtl/lwsp_pkg.sv
// ----------------------------------------------------------------------------
// lwsp_pkg
// Shared types and constants for the level window shortest path core.
// ----------------------------------------------------------------------------
package lwsp_pkg;
  localparam int MaxNodes  = 127;
  localparam int MaxEdges  = 1024;
  localparam int NodeW     = 7;
  localparam int EdgeW     = 10;
  localparam int EdgeCntW  = 11;
  localparam int DistW     = 24;
  localparam int CostW     = 16;
  localparam int LevelW    = 16;
  localparam int PassW     = 8;
  localparam int MaxPasses = MaxNodes + 2;

  localparam logic [DistW-1:0] Unreached = {DistW{1'b1}};
  localparam logic [DistW-1:0] DistMax   = Unreached - 1'b1;

  localparam logic [1:0] FuncItem  = 2'd0;
  localparam logic [1:0] FuncEdge  = 2'd1;
  localparam logic [1:0] FuncSolve = 2'd2;

  localparam logic RegLevelGap  = 1'b0;
  localparam logic RegNodeCount = 1'b1;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [DistW-1:0] dist_t;
endpackage

FILE: hw/rtl/level_window_shortest_path_core.sv
// ----------------------------------------------------------------------------
// level_window_shortest_path_core
// Item and edge store with an iterative windowed shortest path solver.
// ----------------------------------------------------------------------------
// Usage: drive func and the payload with start high while busy is low.
// Item records (func 0) and exchange edges (func 1) are stored on accept;
// busy stays low. A solve (func 2) raises busy and, when finished, pulses
// done for one cycle with min_cost and found; found low gives min_cost 0.
// Configuration: cfg_we with cfg_addr 0 (level_gap) or 1 (node_count), data
// in cfg_wdata; write only while busy is low.
// Solve sequence: after the accept, for each of node_count windows a setup
// state, a mask pass over the node levels, a clear of the distance memory,
// then relaxation passes over all stored edges, each followed by a check, up
// to 129 passes until a pass makes no change; a final state drives done.
// A node count of zero goes straight to done with found low.
// One edge a cycle goes through the shared relax unit, set by the edge memory
// read port. Done results cannot be stalled.
// Reset clears edge count and control, sets level_gap 0 and node_count 1;
// stored levels and edges are undefined until written, no clearing pass needed.
// ----------------------------------------------------------------------------
`include "level_window_shortest_path_core_macros.svh"
module level_window_shortest_path_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 func,
  input  logic [lwsp_pkg::NodeW-1:0] from_node,
  input  logic [lwsp_pkg::NodeW-1:0] to_node,
  input  logic [lwsp_pkg::CostW-1:0] cost,
  input  logic [lwsp_pkg::LevelW-1:0] level,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [15:0]                cfg_wdata,
  output logic                       done,
  output logic [lwsp_pkg::DistW-1:0] min_cost,
  output logic                       found
);
  import lwsp_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWin   = 3'd1;
  localparam logic [2:0] StMask  = 3'd2;
  localparam logic [2:0] StClear = 3'd3;
  localparam logic [2:0] StRelax = 3'd4;
  localparam logic [2:0] StCheck = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [LevelW-1:0] level_gap;
  logic [NodeW-1:0]  node_count;

  logic [LevelW-1:0] level_mem [0:MaxNodes];
  logic [NodeW-1:0]  efrom_mem [0:MaxEdges-1];
  logic [NodeW-1:0]  eto_mem   [0:MaxEdges-1];
  logic [CostW-1:0]  ecost_mem [0:MaxEdges-1];
  dist_t             dist_mem  [0:MaxNodes];
  logic [MaxNodes:0] allowed;

  logic [EdgeCntW-1:0] edge_total;
  logic [2:0]          state;
  logic [NodeW-1:0]    win;
  logic [NodeW:0]      idx;
  logic [EdgeCntW-1:0] eidx;
  logic [PassW-1:0]    pass;
  logic                changed;
  logic [LevelW-1:0]   low;
  dist_t               best;

  // relax pipeline
  logic [NodeW-1:0] s1_from, s1_to, s2_to;
  logic [CostW-1:0] s1_cost, s2_cost;
  logic             s1_v, s2_v, s3_v;
  dist_t            s2_da, s3_cand, rd_d;
  logic [NodeW-1:0] s3_to;
  logic [LevelW-1:0] lv_rd;
  logic             lv_v;
  logic [NodeW-1:0] lv_node;

  logic [LevelW:0] diff;

  // node one distance tracked beside the memory
  dist_t dist_mem_one;

  assign busy = (state != StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      level_gap  <= '0;
      node_count <= NodeW'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegLevelGap:  level_gap  <= cfg_wdata;
        RegNodeCount: node_count <= cfg_wdata[NodeW-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // level memory: written on item records, read for the window base and by the mask sweep
  logic [NodeW-1:0] lv_addr;
  assign lv_addr = (state == StWin) ? win : idx[NodeW-1:0];
  always_ff @(posedge clk) begin
    if (accept && func == FuncItem) level_mem[to_node] <= level;
    lv_rd <= level_mem[lv_addr];
  end

  logic push;
  assign push = accept && (func == FuncItem || func == FuncEdge)
                && (edge_total < EdgeCntW'(MaxEdges));
  always_ff @(posedge clk) begin
    if (push) begin
      efrom_mem[edge_total[EdgeW-1:0]] <= (func == FuncItem) ? '0 : from_node;
      eto_mem[edge_total[EdgeW-1:0]]   <= to_node;
      ecost_mem[edge_total[EdgeW-1:0]] <= cost;
    end
    s1_from <= efrom_mem[eidx[EdgeW-1:0]];
    s1_to   <= eto_mem[eidx[EdgeW-1:0]];
    s1_cost <= ecost_mem[eidx[EdgeW-1:0]];
  end

  // distance memory: two read ports (source, target), one write port
  logic  dwe;
  node_t dwa;
  dist_t dwd;
  always_comb begin
    dwe = 1'b0;
    dwa = '0;
    dwd = Unreached;
    if (state == StClear) begin
      dwe = 1'b1;
      dwa = idx[NodeW-1:0];
      dwd = (idx == '0) ? '0 : Unreached;
    end else if (s3_v) begin
      dwe = 1'b1;
      dwa = s3_to;
      dwd = s3_cand;
    end
  end

  // reads see the write of the same cycle
  dist_t dst_now;
  always_ff @(posedge clk) begin
    if (dwe) dist_mem[dwa] <= dwd;
    rd_d    <= (dwe && dwa == s1_from) ? dwd : dist_mem[s1_from];
    dst_now <= (dwe && dwa == s1_to) ? dwd : dist_mem[s1_to];
  end

  dist_t s2_db;
  always_comb begin
    s2_db = dst_now;
    if (s3_v && s3_to == s2_to) s2_db = s3_cand;
    s2_da = rd_d;
    diff  = {1'b0, lv_rd} - {1'b0, low};
  end

  logic s2_ok;
  logic s2_srcfix;
  dist_t s2_srcval;
  logic [NodeW-1:0] s2_from;
  assign s2_srcfix = s3_v && (s3_to == s2_from);
  assign s2_srcval = s2_srcfix ? s3_cand : s2_da;
  logic [DistW:0] sum2;
  dist_t cand2;
  assign sum2  = {1'b0, s2_srcval} + (DistW+1)'(s2_cost);
  assign cand2 = (sum2 > {1'b0, DistMax}) ? DistMax : sum2[DistW-1:0];
  assign s2_ok = s2_v && (s2_srcval != Unreached) && allowed[s2_to]
                 && (cand2 < s2_db);

  always_ff @(posedge clk) begin
    s2_to   <= s1_to;
    s2_from <= s1_from;
    s2_cost <= s1_cost;
    s3_to   <= s2_to;
    s3_cand <= cand2;
    lv_node <= idx[NodeW-1:0];
    if (state == StMask && idx == '0) low <= lv_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      edge_total <= '0;
      allowed    <= '1;
      done       <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      lv_v <= 1'b0;
      win <= '0; idx <= '0; eidx <= '0; pass <= '0; changed <= 1'b0;
      best <= Unreached; min_cost <= '0; found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (push) edge_total <= edge_total + 1'b1;
      s1_v <= (state == StRelax) && (eidx < edge_total);
      s2_v <= s1_v;
      s3_v <= s2_ok;
      if (s2_ok) changed <= 1'b1;
      lv_v <= (state == StMask) && (idx <= {1'b0, node_count}) && (idx != '0);
      if (lv_v) allowed[lv_node] <= !(lv_rd < low || diff[LevelW-1:0] > level_gap);
      unique case (state)
        StIdle: if (accept && func == FuncSolve) begin
          best <= Unreached;
          win  <= NodeW'(1);
          state <= (node_count == '0) ? StDone : StWin;
        end
        StWin: begin
          idx <= '0;
          allowed <= '1;
          state <= StMask;
        end
        StMask: begin
          idx <= idx + 1'b1;
          if (idx == {1'b0, node_count} + 1'b1) begin
            idx <= '0;
            state <= StClear;
          end
        end
        StClear: begin
          idx <= idx + 1'b1;
          if (idx == (NodeW+1)'(MaxNodes)) begin
            eidx <= '0; pass <= '0; changed <= 1'b0;
            state <= StRelax;
          end
        end
        StRelax: begin
          if (eidx < edge_total) eidx <= eidx + 1'b1;
          else if (!s1_v && !s2_v && !s3_v) state <= StCheck;
        end
        StCheck: begin
          if (changed && pass < PassW'(MaxPasses - 1)) begin
            pass <= pass + 1'b1;
            changed <= 1'b0;
            eidx <= '0;
            state <= StRelax;
          end else begin
            if (dist_mem_one < best) best <= dist_mem_one;
            if (win == node_count) state <= StDone;
            else begin
              win <= win + 1'b1;
              state <= StWin;
            end
          end
        end
        StDone: begin
          done <= 1'b1;
          found <= (best != Unreached);
          min_cost <= (best == Unreached) ? '0 : best;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dwe && dwa == NodeW'(1)) dist_mem_one <= dwd;
  end

  `LWSP_ASSERT(a_done_idle, done, !busy)
  `LWSP_ASSERT(a_found_zero, done && !found, min_cost == '0)
  `LWSP_ASSERT_NEXT(a_solve_busy, accept && func == FuncSolve, busy)
  `LWSP_ASSERT(a_edge_bound, 1'b1, edge_total <= EdgeCntW'(MaxEdges))
endmodule

FILE: dv/tb_level_window_shortest_path_core.sv
// ----------------------------------------------------------------------------
// tb_level_window_shortest_path_core
// Self-checking bench for the windowed shortest path core. A queue-fed driver
// sends item records, exchange edges, solves and unused beats under several
// sender idle rates. An in-bench model predicts each solve answer, and the
// monitor checks each done beat against the oldest prediction. Register
// settings change between phases; the run ends with a solve at the largest node count.
// ----------------------------------------------------------------------------
module tb_level_window_shortest_path_core;
  import lwsp_pkg::*;

  typedef struct packed {
    logic [1:0]        fn;
    logic [NodeW-1:0]  src;
    logic [NodeW-1:0]  dst;
    logic [CostW-1:0]  wt;
    logic [LevelW-1:0] lv;
  } beat_t;

  typedef struct packed {
    dist_t cost_best;
    logic  reach;
  } answer_t;

  localparam logic [1:0] FuncUnused = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = FuncItem;
  logic [NodeW-1:0] from_node = '0;
  logic [NodeW-1:0] to_node = '0;
  logic [CostW-1:0] cost = '0;
  logic [LevelW-1:0] level = '0;
  logic cfg_we = 1'b0;
  logic cfg_addr = RegLevelGap;
  logic [15:0] cfg_wdata = '0;
  logic done;
  logic [DistW-1:0] min_cost;
  logic found;

  level_window_shortest_path_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .from_node(from_node), .to_node(to_node), .cost(cost), .level(level),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .done(done), .min_cost(min_cost), .found(found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [LevelW-1:0] lvl_mem [0:MaxNodes];
  logic [NodeW-1:0]  e_src [0:MaxEdges-1];
  logic [NodeW-1:0]  e_dst [0:MaxEdges-1];
  logic [CostW-1:0]  e_wt  [0:MaxEdges-1];
  int unsigned n_edges = 0;
  int unsigned gap_reg = 0;
  int unsigned count_reg = 1;

  beat_t   pending_beats[$];
  answer_t answers_due[$];
  bit      level_set [0:MaxNodes];
  int      idle_pct = 0;
  logic    beat_taken = 1'b0;
  int      mismatches = 0;

  function automatic void add_edge(int unsigned a, int unsigned b, int unsigned w);
    if (a <= MaxNodes && b <= MaxNodes && n_edges < MaxEdges) begin
      e_src[n_edges] = NodeW'(a);
      e_dst[n_edges] = NodeW'(b);
      e_wt[n_edges] = CostW'(w);
      n_edges++;
    end
  endfunction

  function automatic answer_t solve_network();
    int unsigned dist_v [0:MaxNodes];
    bit ok [0:MaxNodes];
    int unsigned top, low, best, cand, d;
    bit changed;
    answer_t r;
    top = (count_reg > MaxNodes) ? MaxNodes : count_reg;
    best = 32'(Unreached);
    for (int i = 1; i <= top; i++) begin
      low = 32'(lvl_mem[i]);
      for (int j = 0; j <= MaxNodes; j++) begin
        dist_v[j] = 32'(Unreached);
        ok[j] = 1'b1;
      end
      for (int j = 1; j <= top; j++)
        if (lvl_mem[j] < low || lvl_mem[j] - low > gap_reg) ok[j] = 1'b0;
      dist_v[0] = 0;
      changed = 1'b1;
      for (int p = 0; p < MaxPasses && changed; p++) begin
        changed = 1'b0;
        for (int e = 0; e < n_edges; e++) begin
          d = dist_v[e_src[e]];
          if (d != Unreached && ok[e_dst[e]]) begin
            cand = d + 32'(e_wt[e]);
            if (cand > DistMax) cand = 32'(DistMax);
            if (cand < dist_v[e_dst[e]]) begin
              dist_v[e_dst[e]] = cand;
              changed = 1'b1;
            end
          end
        end
      end
      if (dist_v[1] < best) best = dist_v[1];
    end
    r.reach = (best != Unreached);
    r.cost_best = r.reach ? dist_t'(best) : '0;
    return r;
  endfunction

  function automatic void take_beat(beat_t b);
    case (b.fn)
      FuncItem: begin
        lvl_mem[b.dst] = b.lv;
        add_edge(0, 32'(b.dst), 32'(b.wt));
      end
      FuncEdge: add_edge(32'(b.src), 32'(b.dst), 32'(b.wt));
      FuncSolve: answers_due.push_back(solve_network());
      default: ;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !beat_taken)) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
        beat_t b;
        b = pending_beats.pop_front();
        start <= 1'b1;
        func <= b.fn;
        from_node <= b.src;
        to_node <= b.dst;
        cost <= b.wt;
        level <= b.lv;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (done) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected answer: min_cost=%0h found=%0b", min_cost, found);
        end else begin
          answer_t x;
          x = answers_due.pop_front();
          if (x.cost_best !== min_cost || x.reach !== found) begin
            mismatches++;
            if (mismatches <= 10)
              $display("answer mismatch: min_cost exp %0h got %0h, found exp %0b got %0b",
                       x.cost_best, min_cost, x.reach, found);
          end
        end
      end
      if (start && !busy)
        take_beat('{fn: func, src: from_node, dst: to_node, wt: cost, lv: level});
    end
  end

  function automatic void queue_beat(logic [1:0] fn, int unsigned a, int unsigned b,
                                     int unsigned w, int unsigned lv);
    int unsigned top;
    if (fn == FuncSolve) begin
      top = (count_reg > MaxNodes) ? MaxNodes : count_reg;
      for (int j = 1; j <= top; j++)
        if (!level_set[j])
          queue_beat(FuncItem, 0, j, $urandom_range(300), $urandom_range(7));
    end
    if (fn == FuncItem) level_set[b] = 1'b1;
    pending_beats.push_back('{fn: fn, src: NodeW'(a), dst: NodeW'(b), wt: CostW'(w),
                              lv: LevelW'(lv)});
  endfunction

  function automatic int unsigned pick_node();
    if ($urandom_range(19) == 0) return $urandom_range(MaxNodes);
    return $urandom_range(((count_reg > 7) ? 7 : count_reg) + 2);
  endfunction

  function automatic void queue_random(int n);
    int unsigned r, w, lv;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      w = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(200);
      lv = ($urandom_range(7) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(9);
      if (r < 40) queue_beat(FuncItem, $urandom_range(MaxNodes), pick_node(), w, lv);
      else if (r < 85) queue_beat(FuncEdge, pick_node(), pick_node(), w, 0);
      else if (r < 95) queue_beat(FuncSolve, $urandom_range(MaxNodes),
                                  $urandom_range(MaxNodes), $urandom_range(16'hFFFF),
                                  $urandom_range(16'hFFFF));
      else queue_beat(FuncUnused, $urandom_range(MaxNodes), $urandom_range(MaxNodes),
                      $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
    end
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() != 0 || start || busy || answers_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, int unsigned data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= 16'(data);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == RegLevelGap) gap_reg = data & 16'hFFFF;
    else count_reg = data & 7'h7F;
  endtask

  task automatic run_phase(int pct, int unsigned gap, int unsigned cnt, int n);
    drain();
    write_reg(RegLevelGap, gap);
    write_reg(RegNodeCount, cnt);
    idle_pct = pct;
    queue_random(n);
    drain();
  endtask

  initial begin
    for (int j = 0; j <= MaxNodes; j++) begin
      lvl_mem[j] = '0;
      level_set[j] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed
    write_reg(RegLevelGap, 0);
    write_reg(RegNodeCount, 1);
    queue_beat(FuncItem, 0, 1, 16'hFFFF, 16'hFFFF);
    queue_beat(FuncSolve, 0, 0, 0, 0);
    queue_beat(FuncUnused, 7'h7F, 7'h7F, 16'hFFFF, 16'hFFFF);
    queue_beat(FuncItem, 0, 2, 0, 0);
    queue_beat(FuncEdge, 2, 1, 5, 0);
    queue_beat(FuncItem, 0, 0, 3, 16'h5555);
    queue_beat(FuncEdge, 0, 0, 1, 0);
    queue_beat(FuncEdge, 7'h7F, 1, 16'hAAAA, 0);
    queue_beat(FuncItem, 0, 7'h7F, 1, 2);
    queue_beat(FuncSolve, 0, 0, 0, 0);
    drain();
    write_reg(RegNodeCount, 2);
    queue_beat(FuncSolve, 0, 0, 0, 0);
    drain();
    write_reg(RegLevelGap, 16'hFFFF);
    queue_beat(FuncSolve, 0, 0, 0, 0);
    queue_beat(FuncItem, 0, 3, 7, 16'hFFFF);
    queue_beat(FuncEdge, 3, 1, 0, 0);
    queue_beat(FuncSolve, 0, 0, 0, 0);
    drain();
    write_reg(RegNodeCount, 0);
    queue_beat(FuncSolve, 0, 0, 0, 0);
    drain();

    // random
    run_phase(0, 0, 3, 130);
    run_phase(77, 2, 5, 130);
    run_phase(36, 16'hFFFF, 4, 130);
    run_phase(0, $urandom_range(16'hFFFF), 6, 130);
    run_phase(36, 5, $urandom_range(1, 4), 100);

    // largest node count
    drain();
    write_reg(RegLevelGap, 0);
    write_reg(RegNodeCount, MaxNodes);
    idle_pct = 0;
    queue_beat(FuncSolve, 0, 0, 0, 0);
    drain();

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("level_window_shortest_path_core test passed");
    end else begin
      $display("level_window_shortest_path_core test failed");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("level_window_shortest_path_core test failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lwsp_pkg.sv
hw/rtl/level_window_shortest_path_core.sv
dv/tb_level_window_shortest_path_core.sv
